@@ rtl/rcfp_pkg.sv @@
package rcfp_pkg;

  // Frame layout.
  localparam int PAYLOAD_BYTES = 22;
  localparam int ADDR_W        = $clog2(PAYLOAD_BYTES);
  localparam int NUM_CHANNELS  = 16;
  localparam int CH_IDX_W      = $clog2(NUM_CHANNELS);
  localparam int CH_W          = 11;

  // The bit buffer holds a partial channel plus one freshly read byte.
  localparam int BUF_W = CH_W + 8 - 1;
  localparam int NB_W  = $clog2(BUF_W + 1);

  localparam logic [7:0] FRAME_LEN_BYTE  = 8'h18;
  localparam logic [7:0] FRAME_TYPE_BYTE = 8'h16;
  localparam logic [7:0] CRC_POLY        = 8'hD5;

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 26;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Q16    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Q16   = 2'd2;
  localparam logic [7:0]  SYNC_ADDRESS_RST = 8'd238;
  localparam logic [15:0] SCALE_Q16_RST    = 16'd40945;
  localparam logic [25:0] OFFSET_Q16_RST   = 26'd57707027;

  // Result kinds.
  localparam logic KIND_CHANNEL   = 1'b0;
  localparam logic KIND_CRC_ERROR = 1'b1;

  typedef enum logic [4:0] {
    ST_HUNT    = 5'b00001,
    ST_LEN     = 5'b00010,
    ST_TYPE    = 5'b00100,
    ST_PAYLOAD = 5'b01000,
    ST_CRC     = 5'b10000
  } stage_t;

  // Frame verdict handed from the parser to the unpacker.
  typedef struct packed {
    logic good;
    logic bad;
  } emit_cmd_t;

  // Unpacker status seen by the parser.
  typedef struct packed {
    logic busy;
    logic out_full;
  } emit_stat_t;

  // One byte of CRC8, MSB first, no reflection.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // The CRC covers the type byte first, so every frame starts from this value.
  localparam logic [7:0] CRC_SEED = crc8_byte(8'h00, FRAME_TYPE_BYTE);

endpackage

@@ rtl/rcfp_store.sv @@
module rcfp_store (
  input  logic                        clk,
  input  logic                        we,
  input  logic [rcfp_pkg::ADDR_W-1:0] waddr,
  input  logic [7:0]                  wdata,
  input  logic                        re,
  input  logic [rcfp_pkg::ADDR_W-1:0] raddr,
  output logic [7:0]                  rdata
);
  import rcfp_pkg::*;

  logic [7:0] mem [0:PAYLOAD_BYTES-1];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/rcfp_parser.sv @@
module rcfp_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_rx_byte,
  input  logic [7:0]                  sync_address,
  input  rcfp_pkg::emit_stat_t        stat,
  output logic                        mem_we,
  output logic [rcfp_pkg::ADDR_W-1:0] mem_waddr,
  output logic [7:0]                  mem_wdata,
  output rcfp_pkg::emit_cmd_t         cmd,
  output logic [31:0]                 good_frames,
  output logic [31:0]                 bad_frames
);
  import rcfp_pkg::*;

  stage_t            stage_r, stage_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [7:0]        crc_r, crc_nxt;
  logic [31:0]       good_r, good_nxt;
  logic [31:0]       err_r, err_nxt;
  emit_cmd_t         cmd_r, cmd_nxt;
  logic              accept;

  // Payload bytes wait while the unpacker still reads the store; the CRC byte
  // also waits for the result register to drain.
  assign in_stall = ((stage_r == ST_PAYLOAD) && stat.busy) ||
                    ((stage_r == ST_CRC) && (stat.busy || stat.out_full));
  assign accept   = in_valid && !in_stall;
  assign cnt_inc  = cnt_r + ADDR_W'(1);

  always_comb begin
    stage_nxt = stage_r;
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    good_nxt  = good_r;
    err_nxt   = err_r;
    cmd_nxt   = '0;
    mem_we    = 1'b0;
    if (accept) begin
      case (stage_r)
        ST_LEN: begin
          stage_nxt = (in_rx_byte == FRAME_LEN_BYTE) ? ST_TYPE : ST_HUNT;
        end
        ST_TYPE: begin
          if (in_rx_byte == FRAME_TYPE_BYTE) begin
            stage_nxt = ST_PAYLOAD;
            cnt_nxt   = '0;
            crc_nxt   = CRC_SEED;
          end else begin
            stage_nxt = ST_HUNT;
          end
        end
        ST_PAYLOAD: begin
          mem_we  = 1'b1;
          crc_nxt = crc8_byte(crc_r, in_rx_byte);
          cnt_nxt = cnt_inc;
          if (cnt_inc >= ADDR_W'(PAYLOAD_BYTES)) begin
            stage_nxt = ST_CRC;
          end
        end
        ST_CRC: begin
          if (crc_r == in_rx_byte) begin
            good_nxt     = good_r + 32'd1;
            cmd_nxt.good = 1'b1;
          end else begin
            err_nxt     = err_r + 32'd1;
            cmd_nxt.bad = 1'b1;
          end
          stage_nxt = ST_HUNT;
          cnt_nxt   = '0;
        end
        default: begin
          stage_nxt = (in_rx_byte == sync_address) ? ST_LEN : ST_HUNT;
          cnt_nxt   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= ST_HUNT;
      cnt_r   <= '0;
      good_r  <= '0;
      err_r   <= '0;
      cmd_r   <= '0;
    end else begin
      stage_r <= stage_nxt;
      cnt_r   <= cnt_nxt;
      good_r  <= good_nxt;
      err_r   <= err_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
  end

  assign mem_waddr   = cnt_r;
  assign mem_wdata   = in_rx_byte;
  assign cmd         = cmd_r;
  assign good_frames = good_r;
  assign bad_frames  = err_r;

endmodule

@@ rtl/rcfp_unpack.sv @@
module rcfp_unpack (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rcfp_pkg::emit_cmd_t           cmd,
  output rcfp_pkg::emit_stat_t          stat,
  output logic                          rd_en,
  output logic [rcfp_pkg::ADDR_W-1:0]   rd_addr,
  input  logic [7:0]                    rd_data,
  input  logic [15:0]                   scale_q16,
  input  logic [25:0]                   offset_q16,
  input  logic [31:0]                   good_frames,
  input  logic [31:0]                   bad_frames,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_kind,
  output logic [rcfp_pkg::CH_IDX_W-1:0] out_channel_index,
  output logic [rcfp_pkg::CH_W-1:0]     out_raw_value,
  output logic [11:0]                   out_pulse_us,
  output logic [31:0]                   out_good_frames,
  output logic [31:0]                   out_bad_frames,
  output logic                          out_last
);
  import rcfp_pkg::*;

  localparam int PROD_W = CH_W + 16;
  localparam int SUM_W  = PROD_W + 1;

  logic                busy_r;
  logic [ADDR_W-1:0]   rd_addr_r;
  logic                pend_r;
  logic [BUF_W-1:0]    buf_r, buf_nxt, buf_shift;
  logic [NB_W-1:0]     nbits_r, nbits_nxt, nb_shift;
  logic [CH_IDX_W-1:0] ch_r;
  logic                out_valid_r;
  logic                out_free, can_emit, issue;
  logic [CH_W-1:0]     raw;
  logic [PROD_W-1:0]   prod;
  logic [SUM_W-1:0]    sum;

  logic                kind_r, last_r;
  logic [CH_IDX_W-1:0] idx_r;
  logic [CH_W-1:0]     raw_r;
  logic [11:0]         pulse_r;
  logic [31:0]         good_r, err_r;

  assign out_free = !out_valid_r || !out_stall;
  assign can_emit = busy_r && (nbits_r >= NB_W'(CH_W)) && out_free;

  always_comb begin
    buf_shift = can_emit ? (buf_r >> CH_W) : buf_r;
    nb_shift  = can_emit ? (nbits_r - NB_W'(CH_W)) : nbits_r;
    buf_nxt   = buf_shift;
    nbits_nxt = nb_shift;
    if (pend_r) begin
      buf_nxt   = buf_shift | (BUF_W'(rd_data) << nb_shift);
      nbits_nxt = nb_shift + NB_W'(8);
    end
  end

  // A byte is fetched only when no read is in flight and it cannot overflow
  // the buffer.
  assign issue   = busy_r && !pend_r && (rd_addr_r < ADDR_W'(PAYLOAD_BYTES)) &&
                   (nb_shift < NB_W'(CH_W));
  assign rd_en   = issue;
  assign rd_addr = rd_addr_r;

  assign raw  = buf_r[CH_W-1:0];
  assign prod = PROD_W'(raw) * PROD_W'(scale_q16);
  assign sum  = SUM_W'(offset_q16) + SUM_W'(prod);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pend_r      <= 1'b0;
      nbits_r     <= '0;
      rd_addr_r   <= '0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.good) begin
        busy_r    <= 1'b1;
        pend_r    <= 1'b0;
        nbits_r   <= '0;
        rd_addr_r <= '0;
        ch_r      <= '0;
      end else if (busy_r) begin
        pend_r  <= issue;
        nbits_r <= nbits_nxt;
        if (issue) begin
          rd_addr_r <= rd_addr_r + ADDR_W'(1);
        end
        if (can_emit) begin
          ch_r <= ch_r + CH_IDX_W'(1);
          if (ch_r == CH_IDX_W'(NUM_CHANNELS - 1)) begin
            busy_r <= 1'b0;
          end
        end
      end
      if (can_emit || cmd.bad) begin
        out_valid_r <= 1'b1;
      end else if (out_free) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Bytes are ORed into the buffer, so it starts every frame empty.
  always_ff @(posedge clk) begin
    if (cmd.good) begin
      buf_r <= '0;
    end else if (busy_r) begin
      buf_r <= buf_nxt;
    end
    if (can_emit) begin
      kind_r  <= KIND_CHANNEL;
      idx_r   <= ch_r;
      raw_r   <= raw;
      pulse_r <= sum[SUM_W-1:16];
      good_r  <= good_frames;
      err_r   <= bad_frames;
      last_r  <= (ch_r == CH_IDX_W'(NUM_CHANNELS - 1));
    end else if (cmd.bad) begin
      kind_r  <= KIND_CRC_ERROR;
      idx_r   <= '0;
      raw_r   <= '0;
      pulse_r <= '0;
      good_r  <= good_frames;
      err_r   <= bad_frames;
      last_r  <= 1'b1;
    end
  end

  assign stat.busy         = busy_r;
  assign stat.out_full     = out_valid_r;
  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_channel_index = idx_r;
  assign out_raw_value     = raw_r;
  assign out_pulse_us      = pulse_r;
  assign out_good_frames   = good_r;
  assign out_bad_frames    = err_r;
  assign out_last          = last_r;

endmodule

@@ rtl/rc_channel_frame_parser.sv @@
// Channel    Direction  Ports
// in         input      in_valid, in_stall, in_rx_byte
// out        output     out_valid, out_stall, out_kind .. out_last
// cfg        input      cfg_we, cfg_index, cfg_wdata
//
// One received byte is taken per cycle while in_stall is low. The type byte and
// the payload bytes are folded into the CRC as they arrive, and the payload goes
// into a 22-byte store with a registered read port.
// After a good CRC byte, the sixteen channels are unpacked from that store one
// byte at a time (read, then load into the bit buffer), with no new read while
// one is in flight; a bad CRC gives one error result.
// Reset (rst_n low, synchronous) returns the parser to the address hunt and
// clears both frame counters; the payload store is not cleared.
// While channels are being unpacked, payload and CRC bytes are held off with
// in_stall; header bytes keep flowing. out_stall delays the unpacker, and a
// result still held in the output register also holds off the CRC byte.
module rc_channel_frame_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_kind,
  output logic [3:0]                     out_channel_index,
  output logic [10:0]                    out_raw_value,
  output logic [11:0]                    out_pulse_us,
  output logic [31:0]                    out_good_frames,
  output logic [31:0]                    out_bad_frames,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic [rcfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rcfp_pkg::CFG_W-1:0]     cfg_wdata
);
  import rcfp_pkg::*;

  logic [7:0]        sync_address_r;
  logic [15:0]       scale_q16_r;
  logic [25:0]       offset_q16_r;

  emit_cmd_t         cmd;
  emit_stat_t        stat;
  logic              mem_we, rd_en;
  logic [ADDR_W-1:0] mem_waddr, rd_addr;
  logic [7:0]        mem_wdata, rd_data;
  logic [31:0]       good_frames, bad_frames;

  // Configuration registers. Writes to an unused index fall through the case.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_address_r <= SYNC_ADDRESS_RST;
      scale_q16_r    <= SCALE_Q16_RST;
      offset_q16_r   <= OFFSET_Q16_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_ADDRESS: sync_address_r <= cfg_wdata[7:0];
        CFG_SCALE_Q16:    scale_q16_r    <= cfg_wdata[15:0];
        CFG_OFFSET_Q16:   offset_q16_r   <= cfg_wdata[25:0];
        default: begin
        end
      endcase
    end
  end

  // Header checks, CRC and counters; writes payload bytes into the store.
  rcfp_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_rx_byte   (in_rx_byte),
    .sync_address (sync_address_r),
    .stat         (stat),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .cmd          (cmd),
    .good_frames  (good_frames),
    .bad_frames   (bad_frames)
  );

  // Payload store: one write port, one registered read port.
  rcfp_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Reads the store back through a bit buffer, scales each channel and holds
  // the output register.
  rcfp_unpack u_unpack (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .rd_en             (rd_en),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data),
    .scale_q16         (scale_q16_r),
    .offset_q16        (offset_q16_r),
    .good_frames       (good_frames),
    .bad_frames        (bad_frames),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_channel_index (out_channel_index),
    .out_raw_value     (out_raw_value),
    .out_pulse_us      (out_pulse_us),
    .out_good_frames   (out_good_frames),
    .out_bad_frames    (out_bad_frames),
    .out_last          (out_last)
  );

  // The store is never written while the unpacker is still reading it.
  a_no_write_while_unpacking: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && stat.busy))
    else $error("payload store written during unpacking");

  // A frame verdict never arrives while the previous frame is still unpacking.
  a_no_cmd_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.good || cmd.bad) |-> !stat.busy && !out_valid)
    else $error("frame verdict overlaps earlier results");

  // An error transfer carries zero channel fields and closes its frame.
  a_error_result_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_CRC_ERROR) |->
      out_last && out_channel_index == '0 && out_raw_value == '0 && out_pulse_us == '0)
    else $error("malformed crc error result");

endmodule

@@ bench/tb_rc_channel_frame_parser.sv @@
`timescale 1ns / 100ps

// This bench streams serial bytes into the channel frame parser and checks every
// result it emits. The bytes are mostly well-formed frames with random payloads.
// Some frames carry a corrupted CRC, some headers are broken, and noise bytes
// fall between frames. A behavioral copy of the parser runs alongside. It sees
// every byte transfer the block accepts and queues the channel or CRC error
// results that byte must produce.
module tb_rc_channel_frame_parser;
  import rcfp_pkg::*;

  // Index 3 decodes to no register, so a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  // This wait lets a good frame drain its sixteen channels and also covers a
  // byte that is still on its way through.
  localparam int UNPACK_CYCLES = 64;

  typedef struct packed {
    logic        kind;
    logic [3:0]  chan;
    logic [10:0] raw;
    logic [11:0] pulse;
    logic [31:0] good;
    logic [31:0] errs;
    logic        last;
  } chan_result_t;

  logic                 clk;
  logic                 rst_n             = 1'b0;
  logic                 in_valid          = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_rx_byte        = 8'h00;
  logic                 out_valid;
  logic                 out_stall         = 1'b0;
  logic                 out_kind;
  logic [3:0]           out_channel_index;
  logic [10:0]          out_raw_value;
  logic [11:0]          out_pulse_us;
  logic [31:0]          out_good_frames;
  logic [31:0]          out_bad_frames;
  logic                 out_last;
  logic                 cfg_we            = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index         = '0;
  logic [CFG_W-1:0]     cfg_wdata         = '0;

  rc_channel_frame_parser u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_channel_index (out_channel_index),
    .out_raw_value     (out_raw_value),
    .out_pulse_us      (out_pulse_us),
    .out_good_frames   (out_good_frames),
    .out_bad_frames    (out_bad_frames),
    .out_last          (out_last),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // The bench's own copy of the parser state and register file.
  stage_t       parse_stage_m;
  int           pay_fill;
  logic [7:0]   pay_mem [PAYLOAD_BYTES];
  logic [31:0]  good_total;
  logic [31:0]  bad_total;
  logic [7:0]   sync_addr;
  logic [15:0]  scale_m;
  logic [25:0]  offset_m;

  logic [7:0]   byte_q [$];
  chan_result_t frame_results_q [$];
  logic [7:0]   frame_buf [PAYLOAD_BYTES];
  int           pushed_cnt;
  int           accepted_cnt;
  int           mismatches;
  int           send_gap_pct;
  int           recv_stall_pct;
  bit           byte_taken;
  chan_result_t got_want;

  initial begin
    parse_stage_m  = ST_HUNT;
    pay_fill       = 0;
    good_total     = '0;
    bad_total      = '0;
    sync_addr      = SYNC_ADDRESS_RST;
    scale_m        = SCALE_Q16_RST;
    offset_m       = OFFSET_Q16_RST;
    pushed_cnt     = 0;
    accepted_cnt   = 0;
    mismatches     = 0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    byte_taken     = 1'b0;
  end

  // CRC8 with polynomial 0xD5, worked one bit at a time, MSB first.
  function automatic logic [7:0] crc8_d5(input logic [7:0] crc, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[7] ^ b[i];
      crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return crc;
  endfunction

  function automatic chan_result_t make_result(input logic kind, input logic [3:0] chan,
                                               input logic [10:0] raw,
                                               input logic [11:0] pulse, input logic last);
    chan_result_t r;
    r.kind  = kind;
    r.chan  = chan;
    r.raw   = raw;
    r.pulse = pulse;
    r.good  = good_total;
    r.errs  = bad_total;
    r.last  = last;
    return r;
  endfunction

  // Steps the parser copy by one accepted byte. Any results that the byte
  // completes are queued.
  task automatic parse_rx_byte(input logic [7:0] b);
    logic [7:0]                 crc;
    logic [PAYLOAD_BYTES*8-1:0] bits;
    logic [10:0]                raw;
    logic [63:0]                acc;
    case (parse_stage_m)
      ST_LEN: begin
        if (b == FRAME_LEN_BYTE) parse_stage_m = ST_TYPE;
        else parse_stage_m = ST_HUNT;
      end
      ST_TYPE: begin
        if (b == FRAME_TYPE_BYTE) begin
          parse_stage_m = ST_PAYLOAD;
          pay_fill      = 0;
        end else begin
          parse_stage_m = ST_HUNT;
        end
      end
      ST_PAYLOAD: begin
        pay_mem[pay_fill] = b;
        pay_fill++;
        if (pay_fill >= PAYLOAD_BYTES) parse_stage_m = ST_CRC;
      end
      ST_CRC: begin
        crc = crc8_d5(8'h00, FRAME_TYPE_BYTE);
        for (int i = 0; i < PAYLOAD_BYTES; i++) crc = crc8_d5(crc, pay_mem[i]);
        if (crc != b) begin
          bad_total++;
          frame_results_q = {frame_results_q,
                             make_result(KIND_CRC_ERROR, 4'd0, 11'd0, 12'd0, 1'b1)};
        end else begin
          good_total++;
          // The payload is one little-endian bit string. Channel k occupies
          // bits 11k through 11k+10 of it.
          for (int i = 0; i < PAYLOAD_BYTES; i++) bits[8*i +: 8] = pay_mem[i];
          for (int k = 0; k < NUM_CHANNELS; k++) begin
            raw = bits[11*k +: 11];
            acc = 64'(offset_m) + 64'(raw) * 64'(scale_m);
            frame_results_q = {frame_results_q,
                               make_result(KIND_CHANNEL, 4'(k), raw, acc[27:16],
                                           k == NUM_CHANNELS - 1)};
          end
        end
        parse_stage_m = ST_HUNT;
        pay_fill      = 0;
      end
      default: begin
        if (b == sync_addr) parse_stage_m = ST_LEN;
        else parse_stage_m = ST_HUNT;
        pay_fill = 0;
      end
    endcase
  endtask

  task automatic report(input string msg);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Input side. The parser copy is stepped when a byte transfer completes. The
  // flag tells the driver, on the falling edge that follows, that it may move on.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      parse_rx_byte(in_rx_byte);
      accepted_cnt++;
      byte_taken = 1'b1;
    end
  end

  // Driver. A byte stays on the bus until it is taken. After that the next
  // byte comes out of the queue, unless the sender decides to leave a gap. The
  // receiver's stall is drawn again on every falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || byte_taken) begin
      if (byte_q.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
        in_rx_byte <= byte_q.pop_front();
        in_valid   <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    byte_taken = 1'b0;
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Result monitor. Each result transfer is compared with the oldest queued
  // expectation, one field at a time.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (frame_results_q.size() == 0) begin
        report($sformatf("result with nothing pending (kind %0d channel %0d)",
                         out_kind, out_channel_index));
      end else begin
        got_want = frame_results_q.pop_front();
        if (out_kind !== got_want.kind)
          report($sformatf("kind %0d, want %0d", out_kind, got_want.kind));
        if (out_channel_index !== got_want.chan)
          report($sformatf("channel_index %0d, want %0d", out_channel_index, got_want.chan));
        if (out_raw_value !== got_want.raw)
          report($sformatf("raw_value %0d, want %0d (channel %0d)",
                           out_raw_value, got_want.raw, got_want.chan));
        if (out_pulse_us !== got_want.pulse)
          report($sformatf("pulse_us %0d, want %0d (channel %0d)",
                           out_pulse_us, got_want.pulse, got_want.chan));
        if (out_good_frames !== got_want.good)
          report($sformatf("good_frames %0d, want %0d", out_good_frames, got_want.good));
        if (out_bad_frames !== got_want.errs)
          report($sformatf("bad_frames %0d, want %0d", out_bad_frames, got_want.errs));
        if (out_last !== got_want.last)
          report($sformatf("last %0d, want %0d (channel %0d)",
                           out_last, got_want.last, got_want.chan));
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    byte_q = {byte_q, b};
    pushed_cnt++;
  endtask

  // Fills the payload buffer. Mode 0 gives all zeros, mode 1 all ones, and any
  // other mode random bytes with an occasional extreme byte mixed in.
  task automatic fill_payload(input int mode);
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      case (mode)
        0:       frame_buf[i] = 8'h00;
        1:       frame_buf[i] = 8'hFF;
        default: begin
          if ($urandom_range(9) == 0) frame_buf[i] = $urandom_range(1) ? 8'hFF : 8'h00;
          else frame_buf[i] = 8'($urandom);
        end
      endcase
    end
  endtask

  // Queues a complete frame built from the payload buffer. When crc_ok is
  // clear, the CRC byte is flipped by a nonzero mask so that it cannot match.
  task automatic push_frame(input bit crc_ok);
    logic [7:0] crc;
    crc = crc8_d5(8'h00, FRAME_TYPE_BYTE);
    push_byte(sync_addr);
    push_byte(FRAME_LEN_BYTE);
    push_byte(FRAME_TYPE_BYTE);
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      push_byte(frame_buf[i]);
      crc = crc8_d5(crc, frame_buf[i]);
    end
    if (!crc_ok) crc = crc ^ 8'($urandom_range(1, 255));
    push_byte(crc);
  endtask

  // Waits until every queued byte has been taken and every expected result has
  // arrived. It then allows for unpacking that may still be in progress.
  task automatic settle();
    while (accepted_cnt != pushed_cnt || frame_results_q.size() != 0) @(negedge clk);
    repeat (UNPACK_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_SYNC_ADDRESS: sync_addr = val[7:0];
      CFG_SCALE_Q16:    scale_m   = val[15:0];
      CFG_OFFSET_Q16:   offset_m  = val[25:0];
      default:          ;
    endcase
  endtask

  // Registers are rewritten only when the block is idle. Every load also writes
  // the unused index with random data, and that write must have no effect.
  task automatic load_settings(input logic [7:0] sync, input logic [15:0] scale,
                               input logic [25:0] offs);
    settle();
    write_reg(CFG_SYNC_ADDRESS, CFG_W'(sync));
    write_reg(CFG_SCALE_Q16, CFG_W'(scale));
    write_reg(CFG_OFFSET_Q16, offs);
    write_reg(CFG_UNUSED, CFG_W'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random traffic is mostly good frames, with some bad CRCs, broken headers and
  // noise mixed in. Halfway through, the sender holds back until the block has
  // drained. The registers are then reloaded with random values.
  task automatic random_traffic(input int n);
    int start;
    int pick;
    bit paused;
    start  = pushed_cnt;
    paused = 1'b0;
    while (pushed_cnt - start < n) begin
      if (!paused && pushed_cnt - start >= n / 2) begin
        paused = 1'b1;
        load_settings(8'($urandom), 16'($urandom), 26'($urandom));
      end
      pick = $urandom_range(99);
      if (pick < 60) begin
        fill_payload(2);
        push_frame(1'b1);
      end else if (pick < 75) begin
        fill_payload(2);
        push_frame(1'b0);
      end else if (pick < 85) begin
        // A broken header: the length byte or the type byte is random.
        push_byte(sync_addr);
        if ($urandom_range(1)) begin
          push_byte(8'($urandom));
        end else begin
          push_byte(FRAME_LEN_BYTE);
          push_byte(8'($urandom));
        end
      end else begin
        repeat ($urandom_range(1, 6))
          push_byte(($urandom_range(3) == 0) ? sync_addr : 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // First phase. The registers keep their reset values until the halfway
    // reload. The sender leaves few gaps and the receiver stalls often.
    send_gap_pct   = 25;
    recv_stall_pct = 65;

    // Noise at both extremes, which the address hunt should skip.
    push_byte(8'h00);
    push_byte(8'hFF);
    // Frames with all-zero and all-one payloads give every channel its
    // smallest and its largest raw value.
    fill_payload(0);
    push_frame(1'b1);
    fill_payload(1);
    push_frame(1'b1);
    // A corrupted CRC must give exactly one error result.
    fill_payload(2);
    push_frame(1'b0);
    // A length mismatch that is itself the address byte. That byte must not
    // start a new frame, so the header bytes after it are ignored.
    push_byte(sync_addr);
    push_byte(sync_addr);
    push_byte(FRAME_LEN_BYTE);
    push_byte(FRAME_TYPE_BYTE);
    fill_payload(2);
    push_frame(1'b1);
    // A type mismatch that is the address byte, which sends the parser back to the hunt.
    push_byte(sync_addr);
    push_byte(FRAME_LEN_BYTE);
    push_byte(sync_addr);
    push_byte(FRAME_LEN_BYTE);
    fill_payload(2);
    push_frame(1'b1);
    random_traffic(64);

    // Second phase: largest scale and offset with address 0x00, the sender idles and the
    // receiver seldom stalls.
    load_settings(8'h00, 16'hFFFF, 26'h3FFFFFF);
    send_gap_pct   = 65;
    recv_stall_pct = 25;
    random_traffic(64);

    // Third phase: smallest scale and offset, address 0xFF, with back-to-back transfers.
    load_settings(8'hFF, 16'h0000, 26'h0000000);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    random_traffic(64);

    settle();
    if (mismatches == 0) begin
      $display("tb_rc_channel_frame_parser: clean");
    end else begin
      $display("tb_rc_channel_frame_parser: errors");
    end
    $finish;
  end

  // This limit stops a run that does not finish and reports errors.
  initial begin
    #2000000;
    $display("tb_rc_channel_frame_parser: errors");
    $finish;
  end

endmodule

@@ rc_channel_frame_parser.f @@
rtl/rcfp_pkg.sv
rtl/rcfp_store.sv
rtl/rcfp_parser.sv
rtl/rcfp_unpack.sv
rtl/rc_channel_frame_parser.sv
bench/tb_rc_channel_frame_parser.sv
